// ===== sv/tedc_pkg.sv =====
package tedc_pkg;

    // table geometry
    localparam int TABLE_SLOTS = 32;
    localparam int SLOT_W      = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int SLOT_IN_W   = 5;

    // field widths
    localparam int OP_W    = 2;
    localparam int EV_W    = 4;
    localparam int TAG_W   = 8;
    localparam int KIND_W  = 2;
    localparam int RATIO_W = 16;
    localparam int PHASE_W = 4;
    localparam int CFG_IDX_W = 1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FAST_RATIO   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SECOND_RATIO = 1'b1;

    localparam logic [RATIO_W-1:0] RATIO_RST = 16'd10;

    // event codes
    localparam logic [EV_W-1:0] EV_BASE     = 4'd0;
    localparam logic [EV_W-1:0] EV_FAST_DIV = 4'd1;
    localparam logic [EV_W-1:0] EV_SLOW     = 4'd2;
    localparam logic [EV_W-1:0] EV_STAG0    = 4'd3;
    localparam logic [EV_W-1:0] EV_SECOND   = 4'd8;

    // slow phase constants
    localparam logic [PHASE_W-1:0] PHASE_WRAP      = 4'd10;
    localparam logic [PHASE_W-1:0] PHASE_LAST_STAG = 4'd8;
    localparam logic [PHASE_W-1:0] PHASE_SECOND    = 4'd9;

    typedef enum logic [OP_W-1:0] {
        OP_FAST = 2'd0,
        OP_SLOW = 2'd1,
        OP_SUB  = 2'd2,
        OP_DONE = 2'd3
    } op_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_FIRE = 2'd0,
        KIND_SUB  = 2'd1,
        KIND_FULL = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SEARCH,
        ST_DRAIN
    } state_t;

    typedef struct packed {
        kind_t                kind;
        logic [SLOT_IN_W-1:0] slot;
        logic [EV_W-1:0]      ev;
        logic [TAG_W-1:0]     tag;
        logic                 last;
    } res_t;

    typedef struct packed {
        logic valid;
        res_t res;
    } push_t;

    typedef struct packed {
        logic              wr_en;
        logic [SLOT_W-1:0] wr_idx;
        logic [EV_W-1:0]   wr_ev;
        logic [TAG_W-1:0]  wr_tag;
        logic              clr_en;
        logic [SLOT_W-1:0] clr_idx;
    } tbl_cmd_t;

endpackage

// ===== sv/timer_event_callback_dispatcher_core.sv =====
// timer event dispatcher with a 32-slot subscriber table
//
// input channel (in_valid/in_ready) carries one item: a fast tick, a slow
// tick, a subscribe request or a completion report, selected by opcode.
// output channel (out_valid/out_ready) carries result items: callback fires,
// subscribe acknowledgements or table-full reports; last marks the final
// result of an item. config writes (cfg_we, cfg_index, cfg_data) set
// fast_ratio and second_ratio and take effect at once.
//
// sequencing: a tick walks the table one slot per cycle through a single
// compare unit, pausing while a hit waits on a stalled output; a second
// raised event sends it through the table once more, then it enters the
// drain state, and the next item is taken once the block is back in idle.
// a hit is held in a pending register and reaches the output when the next
// hit or the drain state hands it over. a subscribe walks slots until the
// first free one, or reports the table full after the last slot, then
// drains and returns to idle. a completion report is handled in idle and
// yields no result; the walk or drain waits while the output is stalled.
//
// reset clears all active marks and counters and sets both ratios to 10; no
// clearing pass is needed. a stalled receiver holds the output register;
// the table walk pauses on the next hit until that register frees up.
module timer_event_callback_dispatcher_core (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration
    input  logic                            cfg_we,
    input  logic [tedc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tedc_pkg::RATIO_W-1:0]    cfg_data,
    // input items
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [tedc_pkg::OP_W-1:0]       opcode,
    input  logic [tedc_pkg::EV_W-1:0]       event_id,
    input  logic [tedc_pkg::TAG_W-1:0]      handler_tag,
    input  logic [tedc_pkg::SLOT_IN_W-1:0]  slot,
    input  logic                            keep_active,
    // result items
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [tedc_pkg::KIND_W-1:0]     kind,
    output logic [tedc_pkg::SLOT_IN_W-1:0]  slot_res,
    output logic [tedc_pkg::EV_W-1:0]       event_id_res,
    output logic [tedc_pkg::TAG_W-1:0]      handler_tag_res,
    output logic                            last
);
    import tedc_pkg::*;

    logic [RATIO_W-1:0] fast_ratio_reg;
    logic [RATIO_W-1:0] second_ratio_reg;

    logic               out_valid_reg, out_valid_next;
    res_t               out_reg;

    push_t              push;
    tbl_cmd_t           tbl_cmd;
    logic [SLOT_W-1:0]  rd_idx;
    logic               rd_active;
    logic [EV_W-1:0]    rd_event;
    logic [TAG_W-1:0]   rd_tag;
    logic               out_free;

    // ratio registers; the user must write them only while idle, the block itself does not enforce it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fast_ratio_reg   <= RATIO_RST;
            second_ratio_reg <= RATIO_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FAST_RATIO:   fast_ratio_reg   <= cfg_data;
                REG_SECOND_RATIO: second_ratio_reg <= cfg_data;
                default:          fast_ratio_reg   <= fast_ratio_reg;
            endcase
        end
    end

    // subscriber storage
    tedc_table u_table (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (tbl_cmd),
        .rd_idx    (rd_idx),
        .rd_active (rd_active),
        .rd_event  (rd_event),
        .rd_tag    (rd_tag)
    );

    // sequencer: decode, prescalers and slot walk
    tedc_seq u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .opcode       (opcode),
        .event_id     (event_id),
        .handler_tag  (handler_tag),
        .slot         (slot),
        .keep_active  (keep_active),
        .fast_ratio   (fast_ratio_reg),
        .second_ratio (second_ratio_reg),
        .out_free     (out_free),
        .push         (push),
        .tbl_cmd      (tbl_cmd),
        .rd_idx       (rd_idx),
        .rd_active    (rd_active),
        .rd_event     (rd_event),
        .rd_tag       (rd_tag)
    );

    // output register decouples the walk from the receiver
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        if (push.valid)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            out_reg <= push.res;
        end
    end

    assign out_valid       = out_valid_reg;
    assign kind            = out_reg.kind;
    assign slot_res        = out_reg.slot;
    assign event_id_res    = out_reg.ev;
    assign handler_tag_res = out_reg.tag;
    assign last            = out_reg.last;

endmodule

// ===== sv/tedc_table.sv =====
module tedc_table (
    input  logic                       clk,
    input  logic                       rst_n,
    input  tedc_pkg::tbl_cmd_t         cmd,
    input  logic [tedc_pkg::SLOT_W-1:0] rd_idx,
    output logic                       rd_active,
    output logic [tedc_pkg::EV_W-1:0]  rd_event,
    output logic [tedc_pkg::TAG_W-1:0] rd_tag
);
    import tedc_pkg::*;

    logic [TABLE_SLOTS-1:0] active_reg;
    logic [EV_W-1:0]        event_reg [TABLE_SLOTS];
    logic [TAG_W-1:0]       tag_reg   [TABLE_SLOTS];

    // active marks clear at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= '0;
        end
        else
        begin
            if (cmd.wr_en)
            begin
                active_reg[cmd.wr_idx] <= 1'b1;
            end
            if (cmd.clr_en)
            begin
                active_reg[cmd.clr_idx] <= 1'b0;
            end
        end
    end

    // entry payload, meaningful only while active
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            event_reg[cmd.wr_idx] <= cmd.wr_ev;
            tag_reg[cmd.wr_idx]   <= cmd.wr_tag;
        end
    end

    assign rd_active = active_reg[rd_idx];
    assign rd_event  = event_reg[rd_idx];
    assign rd_tag    = tag_reg[rd_idx];

endmodule

// ===== sv/tedc_seq.sv =====
module tedc_seq (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [tedc_pkg::OP_W-1:0]      opcode,
    input  logic [tedc_pkg::EV_W-1:0]      event_id,
    input  logic [tedc_pkg::TAG_W-1:0]     handler_tag,
    input  logic [tedc_pkg::SLOT_IN_W-1:0] slot,
    input  logic                           keep_active,
    input  logic [tedc_pkg::RATIO_W-1:0]   fast_ratio,
    input  logic [tedc_pkg::RATIO_W-1:0]   second_ratio,
    input  logic                           out_free,
    output tedc_pkg::push_t                push,
    output tedc_pkg::tbl_cmd_t             tbl_cmd,
    output logic [tedc_pkg::SLOT_W-1:0]    rd_idx,
    input  logic                           rd_active,
    input  logic [tedc_pkg::EV_W-1:0]      rd_event,
    input  logic [tedc_pkg::TAG_W-1:0]     rd_tag
);
    import tedc_pkg::*;

    localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(TABLE_SLOTS - 1);

    state_t             state_reg, state_next;
    logic [SLOT_W-1:0]  idx_reg, idx_next;
    logic [EV_W-1:0]    cur_ev_reg, cur_ev_next;
    logic [EV_W-1:0]    ev_b_reg, ev_b_next;
    logic               has_b_reg, has_b_next;
    logic [EV_W-1:0]    sub_ev_reg, sub_ev_next;
    logic [TAG_W-1:0]   sub_tag_reg, sub_tag_next;
    logic               pend_valid_reg, pend_valid_next;
    res_t               pend_reg, pend_next;
    logic [RATIO_W-1:0] fast_count_reg, fast_count_next;
    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [RATIO_W-1:0] second_count_reg, second_count_next;

    logic [RATIO_W-1:0] fast_inc;
    logic [RATIO_W-1:0] second_inc;
    logic [PHASE_W-1:0] phase_inc;
    logic [PHASE_W-1:0] phase_wrap;
    logic               match;
    logic               slot_ok;

    assign fast_inc   = fast_count_reg + 1'b1;
    assign second_inc = second_count_reg + 1'b1;
    assign phase_inc  = phase_reg + 1'b1;
    assign phase_wrap = (phase_inc >= PHASE_WRAP) ? '0 : phase_inc;
    // shared compare unit: one slot per cycle unless a hit waits on a stalled output
    assign match      = rd_active && (rd_event == cur_ev_reg);
    assign slot_ok    = (SLOT_IN_W + 1)'(slot) < (SLOT_IN_W + 1)'(TABLE_SLOTS);
    assign rd_idx     = idx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            idx_reg          <= '0;
            has_b_reg        <= 1'b0;
            pend_valid_reg   <= 1'b0;
            fast_count_reg   <= '0;
            phase_reg        <= '0;
            second_count_reg <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            idx_reg          <= idx_next;
            has_b_reg        <= has_b_next;
            pend_valid_reg   <= pend_valid_next;
            fast_count_reg   <= fast_count_next;
            phase_reg        <= phase_next;
            second_count_reg <= second_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_ev_reg  <= cur_ev_next;
        ev_b_reg    <= ev_b_next;
        sub_ev_reg  <= sub_ev_next;
        sub_tag_reg <= sub_tag_next;
        pend_reg    <= pend_next;
    end

    always_comb
    begin
        state_next        = state_reg;
        idx_next          = idx_reg;
        cur_ev_next       = cur_ev_reg;
        ev_b_next         = ev_b_reg;
        has_b_next        = has_b_reg;
        sub_ev_next       = sub_ev_reg;
        sub_tag_next      = sub_tag_reg;
        pend_valid_next   = pend_valid_reg;
        pend_next         = pend_reg;
        fast_count_next   = fast_count_reg;
        phase_next        = phase_reg;
        second_count_next = second_count_reg;
        in_ready          = 1'b0;
        push              = '0;
        tbl_cmd           = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    idx_next = '0;
                    unique case (op_t'(opcode))
                        OP_FAST:
                        begin
                            cur_ev_next = EV_BASE;
                            state_next  = ST_SCAN;
                            if (fast_inc >= fast_ratio)
                            begin
                                fast_count_next = '0;
                                has_b_next      = 1'b1;
                                ev_b_next       = EV_FAST_DIV;
                            end
                            else
                            begin
                                fast_count_next = fast_inc;
                                has_b_next      = 1'b0;
                            end
                        end
                        OP_SLOW:
                        begin
                            cur_ev_next = EV_SLOW;
                            state_next  = ST_SCAN;
                            phase_next  = phase_wrap;
                            has_b_next  = 1'b0;
                            if ((phase_wrap <= PHASE_LAST_STAG) && !phase_wrap[0])
                            begin
                                has_b_next = 1'b1;
                                ev_b_next  = EV_STAG0 + EV_W'(phase_wrap[PHASE_W-1:1]);
                            end
                            else if (phase_wrap == PHASE_SECOND)
                            begin
                                if (second_inc >= second_ratio)
                                begin
                                    second_count_next = '0;
                                    has_b_next        = 1'b1;
                                    ev_b_next         = EV_SECOND;
                                end
                                else
                                begin
                                    second_count_next = second_inc;
                                end
                            end
                        end
                        OP_SUB:
                        begin
                            sub_ev_next  = event_id;
                            sub_tag_next = handler_tag;
                            state_next   = ST_SEARCH;
                        end
                        OP_DONE:
                        begin
                            if (!keep_active && slot_ok)
                            begin
                                tbl_cmd.clr_en  = 1'b1;
                                tbl_cmd.clr_idx = slot[SLOT_W-1:0];
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_SCAN:
            begin
                // a hit must move the held result out first
                if (!(match && pend_valid_reg && !out_free))
                begin
                    if (match)
                    begin
                        push.valid      = pend_valid_reg;
                        push.res        = pend_reg;
                        pend_valid_next = 1'b1;
                        pend_next.kind  = KIND_FIRE;
                        pend_next.slot  = SLOT_IN_W'(idx_reg);
                        pend_next.ev    = cur_ev_reg;
                        pend_next.tag   = rd_tag;
                        pend_next.last  = 1'b0;
                    end
                    if (idx_reg == LAST_IDX)
                    begin
                        idx_next = '0;
                        if (has_b_reg)
                        begin
                            cur_ev_next = ev_b_reg;
                            has_b_next  = 1'b0;
                        end
                        else
                        begin
                            state_next = ST_DRAIN;
                        end
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end

            ST_SEARCH:
            begin
                if (!rd_active)
                begin
                    tbl_cmd.wr_en   = 1'b1;
                    tbl_cmd.wr_idx  = idx_reg;
                    tbl_cmd.wr_ev   = sub_ev_reg;
                    tbl_cmd.wr_tag  = sub_tag_reg;
                    pend_valid_next = 1'b1;
                    pend_next.kind  = KIND_SUB;
                    pend_next.slot  = SLOT_IN_W'(idx_reg);
                    pend_next.ev    = sub_ev_reg;
                    pend_next.tag   = sub_tag_reg;
                    pend_next.last  = 1'b0;
                    state_next      = ST_DRAIN;
                end
                else if (idx_reg == LAST_IDX)
                begin
                    pend_valid_next = 1'b1;
                    pend_next.kind  = KIND_FULL;
                    pend_next.slot  = '0;
                    pend_next.ev    = sub_ev_reg;
                    pend_next.tag   = sub_tag_reg;
                    pend_next.last  = 1'b0;
                    state_next      = ST_DRAIN;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            ST_DRAIN:
            begin
                if (!pend_valid_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    push.valid      = 1'b1;
                    push.res        = pend_reg;
                    push.res.last   = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/tedc_checker.sv =====
module tedc_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            in_valid,
    input logic                            in_ready,
    input logic [tedc_pkg::OP_W-1:0]       opcode,
    input logic                            out_valid,
    input logic                            out_ready,
    input logic [tedc_pkg::KIND_W-1:0]     kind,
    input logic [tedc_pkg::SLOT_IN_W-1:0]  slot_res,
    input logic                            last
);
    import tedc_pkg::*;

    // a held result stays put while the receiver stalls
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(slot_res))
        else $error("result changed while stalled");

    // subscribe answers are single results
    a_sub_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == KIND_SUB || kind == KIND_FULL) |-> last)
        else $error("subscribe answer without last");

    // table full reports slot zero
    a_full_slot: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_FULL |-> slot_res == '0)
        else $error("table full with nonzero slot");

    // ticks and subscribes drop ready right after they are accepted
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && opcode != OP_DONE |=> !in_ready)
        else $error("ready right after a multi-cycle item");

endmodule

bind timer_event_callback_dispatcher_core tedc_checker u_tedc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .opcode    (opcode),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .kind      (kind),
    .slot_res  (slot_res),
    .last      (last)
);
